### rtl/dcofg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcofg_pkg
// Shared types, constants and the quarter-wave cosine entry builder.
// ----------------------------------------------------------------------------
package dcofg_pkg;

    // Field and register widths
    localparam int DC_W          = 16;
    localparam int SAMPLE_W      = 16;
    localparam int PHASE_STEP_W  = 23;
    localparam int VOLUME_STEP_W = 24;
    localparam int COS_MAG_W     = 16;
    localparam int DC_PROD_W     = 31;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;

    // Register reset values
    localparam logic [PHASE_STEP_W-1:0]  PHASE_STEP_RST  = 23'd17476;
    localparam logic [VOLUME_STEP_W-1:0] VOLUME_STEP_RST = 24'd3884;

    // Register index (paddr[2])
    localparam logic REG_PHASE_STEP  = 1'b0;
    localparam logic REG_VOLUME_STEP = 1'b1;

    // Request commands
    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Polynomial constants for cos over a quarter turn, Q30
    localparam logic [63:0] K_C2  = 64'd1324675879;
    localparam logic [63:0] K_C4  = 64'd272375560;
    localparam logic [63:0] K_C6  = 64'd22401992;
    localparam logic [63:0] K_C8  = 64'd987048;
    localparam logic [63:0] K_C10 = 64'd27061;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // Signed cosine as sign and magnitude
    typedef struct packed {
        logic                 neg;
        logic [COS_MAG_W-1:0] mag;
    } t_cos_val;

    // Q15 cosine of a Q30 fraction of a quarter turn
    function automatic logic [COS_MAG_W-1:0] cos_entry(input logic [63:0] x);
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] c;
        logic [63:0] q;
        s = (x * x) >> 30;
        r = K_C8 - ((s * K_C10) >> 30);
        r = K_C6 - ((s * r) >> 30);
        r = K_C4 - ((s * r) >> 30);
        r = K_C2 - ((s * r) >> 30);
        t = (s * r) >> 30;
        c = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
        q = (c + (64'd1 << 14)) >> 15;
        if (q > 64'd32768) begin
            q = 64'd32768;
        end
        return q[COS_MAG_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/dcofg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcofg_if
// Valid/ready channels for sample requests and faded samples.
// ----------------------------------------------------------------------------
interface dcofg_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] offset;

    modport source (output valid, output command, output offset, input ready);
    modport sink   (input valid, input command, input offset, output ready);
endinterface

interface dcofg_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    logic        active;

    modport source (output valid, output sample, output active, input ready);
    modport sink   (input valid, input sample, input active, output ready);
endinterface
`default_nettype wire

### rtl/dcofg_cos.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcofg_cos
// Quarter-wave cosine lookup with quadrant folding; registered output.
// ----------------------------------------------------------------------------
module dcofg_cos
    import dcofg_pkg::*;
#(
    parameter int PHASE_BITS      = 24,
    parameter int COS_TABLE_DEPTH = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [PHASE_BITS-1:0] i_phase,
    output t_cos_val                   o_cos
);

    localparam int FRAC_W = PHASE_BITS - 2;
    localparam int IDX_W  = $clog2(COS_TABLE_DEPTH + 1);

    localparam logic [1:0] QUAD_FALL   = 2'd0;
    localparam logic [1:0] QUAD_NEG_LO = 2'd1;
    localparam logic [1:0] QUAD_NEG_HI = 2'd2;
    localparam logic [1:0] QUAD_RISE   = 2'd3;

    logic [COS_MAG_W-1:0]    w_tab [0:COS_TABLE_DEPTH];
    logic [FRAC_W+IDX_W-1:0] w_scaled;
    logic [IDX_W-1:0]        w_idx;
    logic [IDX_W-1:0]        w_mirror;
    t_cos_val                n_cos;
    t_cos_val                r_cos;

    // Build the constant quarter-wave table
    for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_tab
        localparam logic [63:0] X = (64'(k) << 30) / COS_TABLE_DEPTH;
        assign w_tab[k] = cos_entry(X);
    end

    // Scale the in-quadrant fraction to a table index
    assign w_scaled = (FRAC_W+IDX_W)'(i_phase[FRAC_W-1:0])
                    * (FRAC_W+IDX_W)'(COS_TABLE_DEPTH);
    assign w_idx    = w_scaled[FRAC_W+IDX_W-1:FRAC_W];
    assign w_mirror = IDX_W'(COS_TABLE_DEPTH) - w_idx;

    // Fold the quadrant onto the table
    always_comb begin
        unique case (i_phase[PHASE_BITS-1:PHASE_BITS-2])
            QUAD_FALL:   n_cos = '{neg: 1'b0, mag: w_tab[w_idx]};
            QUAD_NEG_LO: n_cos = '{neg: 1'b1, mag: w_tab[w_mirror]};
            QUAD_NEG_HI: n_cos = '{neg: 1'b1, mag: w_tab[w_idx]};
            QUAD_RISE:   n_cos = '{neg: 1'b0, mag: w_tab[w_mirror]};
            default:     n_cos = '{neg: 1'b0, mag: '0};
        endcase
    end

    // Hold the lookup result
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= n_cos;
        end
    end

    assign o_cos = r_cos;

endmodule
`default_nettype wire

### rtl/dcofg_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcofg_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module dcofg_mul #(
    parameter int A_W = 31,
    parameter int B_W = 24
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [A_W-1:0]     i_a,
    input  wire logic [B_W-1:0]     i_b,
    output logic      [A_W+B_W-1:0] o_p
);

    logic [A_W+B_W-1:0] r_p;

    // Multiply and hold
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
        end
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

### rtl/dc_offset_fade_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dc_offset_fade_generator
// Fades a held DC offset to silence with a cosine wave under a linear
// volume envelope; one shared multiplier runs twice per sample while fading.
// ----------------------------------------------------------------------------
// Sample request: S_COS reads the table, S_MUL1 and S_MUL2 use the shared
//   multiplier, S_RES registers the result once the output slot is free,
//   then S_IDLE takes the next request. After the fade ends: S_RES only.
// Restart request: taken in S_IDLE, no result.
// Synchronous active-low reset: phase zero, full volume, step registers at
//   their defaults, no result pending.
module dc_offset_fade_generator
    import dcofg_pkg::*;
#(
    parameter int PHASE_BITS       = 24,
    parameter int VOLUME_FRAC_BITS = 23,
    parameter int COS_TABLE_DEPTH  = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    dcofg_req_if.sink                  i_req,
    dcofg_res_if.source                o_res,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int VOL_W  = VOLUME_FRAC_BITS + 1;
    localparam int VW2    = (VOL_W > VOLUME_STEP_W) ? VOL_W : VOLUME_STEP_W;
    localparam int PROD_W = DC_PROD_W + VOL_W;
    localparam int SHIFT  = 15 + VOLUME_FRAC_BITS;
    localparam int SH_W   = PROD_W - SHIFT;
    localparam logic [VOL_W-1:0] VOL_FULL = VOL_W'(1) << VOLUME_FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COS,
        S_MUL1,
        S_MUL2,
        S_RES
    } t_state;

    t_state                   r_state,      n_state;
    logic [PHASE_BITS-1:0]    r_phase,      n_phase;
    logic [VOL_W-1:0]         r_vol,        n_vol;
    logic [DC_W-1:0]          r_dc_mag,     n_dc_mag;
    logic                     r_dc_neg,     n_dc_neg;
    logic                     r_neg,        n_neg;
    logic                     r_zero,       n_zero;
    logic                     r_out_valid,  n_out_valid;
    logic [SAMPLE_W-1:0]      r_out_sample, n_out_sample;
    logic                     r_out_active, n_out_active;
    logic [PHASE_STEP_W-1:0]  r_phase_step, n_phase_step;
    logic [VOLUME_STEP_W-1:0] r_vol_step,   n_vol_step;

    t_cos_val                 w_cos;
    logic                     w_mul_en;
    logic [DC_PROD_W-1:0]     w_mul_a;
    logic [VOL_W-1:0]         w_mul_b;
    logic [PROD_W-1:0]        w_prod;
    logic [VW2-1:0]           w_vol_ext;
    logic [VW2-1:0]           w_step_ext;
    logic [SH_W-1:0]          w_mag;
    logic [SH_W-1:0]          w_sat;
    logic [SAMPLE_W-1:0]      w_res;
    logic                     w_req_fire;
    logic                     w_cfg_wr;
    logic                     w_slot_free;

    // Handshakes
    assign i_req.ready  = (r_state == S_IDLE);
    assign w_req_fire   = i_req.valid && i_req.ready;
    assign o_res.valid  = r_out_valid;
    assign o_res.sample = r_out_sample;
    assign o_res.active = r_out_active;
    assign w_slot_free  = !r_out_valid || o_res.ready;

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            REG_PHASE_STEP:  prdata = APB_DATA_W'(r_phase_step);
            REG_VOLUME_STEP: prdata = APB_DATA_W'(r_vol_step);
            default:         prdata = '0;
        endcase
    end

    // Cosine lookup
    dcofg_cos #(
        .PHASE_BITS      (PHASE_BITS),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_cos (
        .i_clk   (i_clk),
        .i_en    (r_state == S_COS),
        .i_phase (r_phase),
        .o_cos   (w_cos)
    );

    // Shared multiplier: offset times cosine, then times volume
    assign w_mul_en = (r_state == S_MUL1) || (r_state == S_MUL2);
    assign w_mul_a  = (r_state == S_MUL1) ? DC_PROD_W'(w_cos.mag) : w_prod[DC_PROD_W-1:0];
    assign w_mul_b  = (r_state == S_MUL1) ? VOL_W'(r_dc_mag) : r_vol;

    dcofg_mul #(
        .A_W (DC_PROD_W),
        .B_W (VOL_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // Truncate toward zero and saturate
    assign w_vol_ext  = VW2'(r_vol);
    assign w_step_ext = VW2'(r_vol_step);
    assign w_mag      = w_prod[PROD_W-1:SHIFT];

    always_comb begin
        if (r_neg) begin
            w_sat = (w_mag > SH_W'(32768)) ? SH_W'(32768) : w_mag;
            w_res = SAMPLE_W'(~w_sat + SH_W'(1));
        end else begin
            w_sat = (w_mag > SH_W'(32767)) ? SH_W'(32767) : w_mag;
            w_res = w_sat[SAMPLE_W-1:0];
        end
    end

    // Sequencer and register next values
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_vol        = r_vol;
        n_dc_mag     = r_dc_mag;
        n_dc_neg     = r_dc_neg;
        n_neg        = r_neg;
        n_zero       = r_zero;
        n_out_valid  = r_out_valid;
        n_out_sample = r_out_sample;
        n_out_active = r_out_active;
        n_phase_step = r_phase_step;
        n_vol_step   = r_vol_step;

        // Drop a taken result
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        // Register writes
        if (w_cfg_wr && pready) begin
            unique case (paddr[2])
                REG_PHASE_STEP:  n_phase_step = pwdata[PHASE_STEP_W-1:0];
                REG_VOLUME_STEP: n_vol_step   = pwdata[VOLUME_STEP_W-1:0];
                default:         n_phase_step = r_phase_step;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_req_fire) begin
                    n_dc_neg = i_req.offset[DC_W-1];
                    n_dc_mag = i_req.offset[DC_W-1] ? (~i_req.offset + DC_W'(1))
                                                    : i_req.offset;
                    if (i_req.command == CMD_RESTART) begin
                        n_phase = '0;
                        n_vol   = VOL_FULL;
                    end else if (r_vol == '0) begin
                        n_zero  = 1'b1;
                        n_state = S_RES;
                    end else begin
                        n_zero  = 1'b0;
                        n_vol   = (w_vol_ext > w_step_ext) ? VOL_W'(w_vol_ext - w_step_ext)
                                                           : '0;
                        n_phase = r_phase + PHASE_BITS'(r_phase_step);
                        n_state = S_COS;
                    end
                end
            end
            S_COS: begin
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_neg   = r_dc_neg ^ w_cos.neg;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_state = S_RES;
            end
            S_RES: begin
                // Hold until the output slot is free
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = r_zero ? '0 : w_res;
                    n_out_active = !r_zero;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= '0;
            r_vol        <= VOL_FULL;
            r_zero       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_sample <= '0;
            r_out_active <= 1'b0;
            r_phase_step <= PHASE_STEP_RST;
            r_vol_step   <= VOLUME_STEP_RST;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_vol        <= n_vol;
            r_zero       <= n_zero;
            r_out_valid  <= n_out_valid;
            r_out_sample <= n_out_sample;
            r_out_active <= n_out_active;
            r_phase_step <= n_phase_step;
            r_vol_step   <= n_vol_step;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_dc_mag <= n_dc_mag;
        r_dc_neg <= n_dc_neg;
        r_neg    <= n_neg;
    end

    // Restart returns the fade to phase zero and full volume
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_fire && i_req.command == CMD_RESTART)
        |=> (r_phase == '0 && r_vol == VOL_FULL && r_state == S_IDLE))
        else $error("restart did not reset fade state");

    // Silence carries a zero sample
    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_active) |-> (r_out_sample == '0))
        else $error("inactive result with nonzero sample");

    // Volume never rises above full scale
    a_vol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vol <= VOL_FULL)
        else $error("volume above full scale");

    // A finished result waits while the output slot is taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES && r_out_valid && !o_res.ready)
        |=> (r_state == S_RES && r_out_valid))
        else $error("result overwrote a pending output");

    // Silence only follows a finished fade
    a_zero_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_fire && i_req.command == CMD_SAMPLE && r_vol == '0)
        |=> (r_state == S_RES && r_zero))
        else $error("finished fade did not take the silence path");

endmodule
`default_nettype wire
